>>> rtl/core/teq_pkg.sv
// ---------------------------------------------------------------------------
// teq_pkg
// Shared constants, types and helpers of the timed event queue.
// ---------------------------------------------------------------------------
package teq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W      = 32;
  localparam int DELTA_W     = 16;
  localparam int THR_W       = 16;
  localparam int PEND_W      = 7;

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_TOGGLE = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_DROP    = 2'd2;

  typedef struct packed {
    logic [1:0]       target;
    logic [1:0]       source;
    logic             source_device;
    logic [1:0]       axis;
    logic             abs_or_delta;
    logic             greater_or_less;
    logic [THR_W-1:0] threshold;
    logic [1:0]       relay_channel;
  } ev_t;

  typedef struct packed {
    logic [TIME_W-1:0] ev_time;
    ev_t               ev;
  } slot_t;

  typedef struct packed {
    logic [1:0]         op;
    slot_t              slot;
    logic [DELTA_W-1:0] tick_delta;
  } item_t;

  typedef struct packed {
    logic [1:0]        kind;
    ev_t               ev;
    logic [TIME_W-1:0] timer_now;
    logic [PEND_W-1:0] pending_count;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_INS_FIN,
    ST_TICK_CMP
  } state_t;

  typedef struct packed {
    logic       load_item;
    logic       scan_init;
    logic       scan_step;
    logic       head_rd;
    logic       shift_wr;
    logic       put_wr;
    logic       put_head;
    logic       cnt_inc;
    logic       pop;
    logic       timer_adv;
    logic       run_flip;
    logic       res_load;
    logic [1:0] res_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       running;
    logic       greater;
    logic       scan_last;
    logic       due;
    logic       out_busy;
  } dp_stat_t;

  // Map a queue position (0 = head) onto a table address of the ring.
  function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] offs);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, offs};
    if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

>>> rtl/core/teq_in_if.sv
// ---------------------------------------------------------------------------
// teq_in_if
// Request channel of the timed event queue: valid/ready and item fields.
// ---------------------------------------------------------------------------
interface teq_in_if import teq_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [TIME_W-1:0]  event_time;
  logic [1:0]         target;
  logic [1:0]         source_id;
  logic               source_device;
  logic [1:0]         axis;
  logic               abs_or_delta;
  logic               greater_or_less;
  logic [THR_W-1:0]   threshold;
  logic [1:0]         relay_channel;
  logic [DELTA_W-1:0] tick_delta;

  modport source (
    output valid, op, event_time, target, source_id, source_device, axis,
           abs_or_delta, greater_or_less, threshold, relay_channel, tick_delta,
    input  ready
  );

  modport sink (
    input  valid, op, event_time, target, source_id, source_device, axis,
           abs_or_delta, greater_or_less, threshold, relay_channel, tick_delta,
    output ready
  );

endinterface

>>> rtl/core/teq_out_if.sv
// ---------------------------------------------------------------------------
// teq_out_if
// Result channel of the timed event queue: valid/ready and result fields.
// ---------------------------------------------------------------------------
interface teq_out_if import teq_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [1:0]        out_target;
  logic [1:0]        out_source;
  logic              out_source_device;
  logic [1:0]        out_axis;
  logic              out_abs_or_delta;
  logic              out_greater_or_less;
  logic [THR_W-1:0]  out_threshold;
  logic [1:0]        out_relay_channel;
  logic [TIME_W-1:0] timer_now;
  logic [PEND_W-1:0] pending_count;

  modport source (
    output valid, kind, out_target, out_source, out_source_device, out_axis,
           out_abs_or_delta, out_greater_or_less, out_threshold,
           out_relay_channel, timer_now, pending_count,
    input  ready
  );

  modport sink (
    input  valid, kind, out_target, out_source, out_source_device, out_axis,
           out_abs_or_delta, out_greater_or_less, out_threshold,
           out_relay_channel, timer_now, pending_count,
    output ready
  );

endinterface

>>> rtl/core/teq_ctrl.sv
// ---------------------------------------------------------------------------
// teq_ctrl
// Sequencer of the timed event queue: dispatches each request and steps the
// sorted-insert scan and the head release.
// ---------------------------------------------------------------------------
module teq_ctrl import teq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (stat.op)
          OP_INSERT: begin
            if (stat.full) begin
              if (!stat.out_busy) state_nxt = ST_IDLE;
            end else if (stat.empty) begin
              state_nxt = ST_INS_PUT;
            end else begin
              state_nxt = ST_INS_CMP;
            end
          end
          OP_TICK: begin
            if (stat.running) begin
              state_nxt = ST_TICK_CMP;
            end else if (!stat.out_busy) begin
              state_nxt = ST_IDLE;
            end
          end
          default: begin
            if (!stat.out_busy) state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_INS_CMP: begin
        if (stat.greater) begin
          if (stat.scan_last) state_nxt = ST_INS_PUT;
        end else begin
          state_nxt = ST_INS_FIN;
        end
      end
      ST_INS_PUT: begin
        state_nxt = ST_INS_FIN;
      end
      ST_INS_FIN, ST_TICK_CMP: begin
        if (!stat.out_busy) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_DISPATCH: begin
        case (stat.op)
          OP_INSERT: begin
            if (stat.full) begin
              cmd.res_load = !stat.out_busy;
              cmd.res_kind = KIND_DROP;
            end else if (!stat.empty) begin
              cmd.scan_init = 1'b1;
            end
          end
          OP_TICK: begin
            if (stat.running) begin
              cmd.timer_adv = 1'b1;
              cmd.head_rd   = 1'b1;
            end else begin
              cmd.res_load = !stat.out_busy;
              cmd.res_kind = KIND_NONE;
            end
          end
          OP_TOGGLE: begin
            cmd.run_flip = !stat.out_busy;
            cmd.res_load = !stat.out_busy;
            cmd.res_kind = KIND_NONE;
          end
          default: begin
            cmd.res_load = !stat.out_busy;
            cmd.res_kind = KIND_NONE;
          end
        endcase
      end
      ST_INS_CMP: begin
        // shift the larger entry up one place, or drop the new one in above it
        if (stat.greater) begin
          cmd.shift_wr  = 1'b1;
          cmd.scan_step = !stat.scan_last;
        end else begin
          cmd.put_wr = 1'b1;
        end
      end
      ST_INS_PUT: begin
        cmd.put_wr   = 1'b1;
        cmd.put_head = 1'b1;
      end
      ST_INS_FIN: begin
        cmd.cnt_inc  = !stat.out_busy;
        cmd.res_load = !stat.out_busy;
        cmd.res_kind = KIND_NONE;
      end
      ST_TICK_CMP: begin
        cmd.res_load = !stat.out_busy;
        if (!stat.empty && stat.due) begin
          cmd.pop      = !stat.out_busy;
          cmd.res_kind = KIND_RELEASE;
        end else begin
          cmd.res_kind = KIND_NONE;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/core/teq_dp.sv
// ---------------------------------------------------------------------------
// teq_dp
// Datapath of the timed event queue: ring table of events, score timer,
// scan pointer and the result register.
// ---------------------------------------------------------------------------
module teq_dp import teq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  item_t     in_item,
  input  ctrl_cmd_t cmd,
  input  logic      out_ready,
  output dp_stat_t  stat,
  output logic      out_valid,
  output result_t   out_res
);

  slot_t slot_mem [QUEUE_DEPTH];

  item_t             item_r;
  slot_t             rd_data_r;
  logic [TIME_W-1:0] timer_r,     timer_nxt;
  logic              running_r,   running_nxt;
  logic [CNT_W-1:0]  count_r,     count_nxt;
  logic [IDX_W-1:0]  head_r,      head_nxt;
  logic [IDX_W-1:0]  j_r,         j_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           res_r,       res_nxt;

  logic [CNT_W-1:0]  cnt_m1;
  logic [IDX_W-1:0]  rd_offs;
  logic [IDX_W-1:0]  wr_offs;
  logic              rd_en;
  logic              wr_en;
  slot_t             wr_data;
  logic [TIME_W:0]   timer_sum;
  logic [TIME_W-1:0] timer_adv;

  always_comb begin
    cnt_m1 = count_r - CNT_W'(1);
    if (cmd.scan_init) begin
      rd_offs = cnt_m1[IDX_W-1:0];
    end else if (cmd.scan_step) begin
      rd_offs = j_r - IDX_W'(1);
    end else begin
      rd_offs = '0;
    end
    rd_en   = cmd.scan_init | cmd.scan_step | cmd.head_rd;
    wr_en   = cmd.shift_wr | cmd.put_wr;
    wr_offs = cmd.put_head ? '0 : j_r + IDX_W'(1);
    wr_data = cmd.shift_wr ? rd_data_r : item_r.slot;
  end

  // saturate the timer at all ones
  always_comb begin
    timer_sum = {1'b0, timer_r} + (TIME_W+1)'(item_r.tick_delta);
    timer_adv = timer_sum[TIME_W] ? '1 : timer_sum[TIME_W-1:0];
    timer_nxt = cmd.timer_adv ? timer_adv : timer_r;
  end

  always_comb begin
    running_nxt = cmd.run_flip ? ~running_r : running_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = cnt_m1;
    end else begin
      count_nxt = count_r;
    end
    head_nxt = cmd.pop ? phys_addr(head_r, IDX_W'(1)) : head_r;
    j_nxt    = (cmd.scan_init | cmd.scan_step) ? rd_offs : j_r;
  end

  always_comb begin
    res_nxt.kind          = cmd.res_kind;
    res_nxt.ev            = (cmd.res_kind == KIND_RELEASE) ? rd_data_r.ev : '0;
    res_nxt.timer_now     = timer_nxt;
    res_nxt.pending_count = PEND_W'(count_nxt);
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_comb begin
    stat.op        = item_r.op;
    stat.full      = (count_r == CNT_W'(QUEUE_DEPTH));
    stat.empty     = (count_r == '0);
    stat.running   = running_r;
    stat.greater   = (rd_data_r.ev_time > item_r.slot.ev_time);
    stat.scan_last = (j_r == '0);
    stat.due       = (timer_r >= rd_data_r.ev_time);
    stat.out_busy  = out_valid_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[phys_addr(head_r, wr_offs)] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= slot_mem[phys_addr(head_r, rd_offs)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r     <= '0;
      running_r   <= 1'b0;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      timer_r     <= timer_nxt;
      running_r   <= running_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_item;
    end
    if (cmd.res_load) begin
      res_r <= res_nxt;
    end
    j_r <= j_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

>>> rtl/core/timed_event_queue.sv
// A toggle, stopped tick, unused op or dropped insert registers its result in
// the dispatch state, a running tick in the tick-compare state after reading
// the head, an insert in the finish state after each stored event with a later
// time is shifted up one table slot; a stalled output adds its stall.
// Throughput: one request at a time; the next is taken the cycle after the
// result is registered, while that result may still wait on the output.
// ---------------------------------------------------------------------------
// timed_event_queue
// Time-ordered queue of sensor-condition events with a running score timer.
// Reset: synchronous; clears timer, run flag, count and control, not table.
// ---------------------------------------------------------------------------
module timed_event_queue import teq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  teq_in_if.sink    in_ch,
  teq_out_if.source out_ch
);

  item_t     in_item;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  result_t   res;
  logic      res_valid;
  logic      in_ready;

  always_comb begin
    in_item.op                   = in_ch.op;
    in_item.slot.ev_time         = in_ch.event_time;
    in_item.slot.ev.target       = in_ch.target;
    in_item.slot.ev.source       = in_ch.source_id;
    in_item.slot.ev.source_device = in_ch.source_device;
    in_item.slot.ev.axis         = in_ch.axis;
    in_item.slot.ev.abs_or_delta = in_ch.abs_or_delta;
    in_item.slot.ev.greater_or_less = in_ch.greater_or_less;
    in_item.slot.ev.threshold    = in_ch.threshold;
    in_item.slot.ev.relay_channel = in_ch.relay_channel;
    in_item.tick_delta           = in_ch.tick_delta;
  end

  teq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  teq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .out_valid (res_valid),
    .out_res   (res)
  );

  assign in_ch.ready                = in_ready;
  assign out_ch.valid               = res_valid;
  assign out_ch.kind                = res.kind;
  assign out_ch.out_target          = res.ev.target;
  assign out_ch.out_source          = res.ev.source;
  assign out_ch.out_source_device   = res.ev.source_device;
  assign out_ch.out_axis            = res.ev.axis;
  assign out_ch.out_abs_or_delta    = res.ev.abs_or_delta;
  assign out_ch.out_greater_or_less = res.ev.greater_or_less;
  assign out_ch.out_threshold       = res.ev.threshold;
  assign out_ch.out_relay_channel   = res.ev.relay_channel;
  assign out_ch.timer_now           = res.timer_now;
  assign out_ch.pending_count       = res.pending_count;

endmodule

>>> rtl/core/teq_checker.sv
// ---------------------------------------------------------------------------
// teq_checker
// Port-level checks of the timed event queue, bound to the top level.
// ---------------------------------------------------------------------------
module teq_checker import teq_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        kind,
  input logic [1:0]        target,
  input logic [THR_W-1:0]  threshold,
  input logic [TIME_W-1:0] timer_now,
  input logic [PEND_W-1:0] pending_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(timer_now)
                                && $stable(pending_count))
    else $error("stalled result changed");

  // one request in flight: ready drops right after a request is taken
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != KIND_RELEASE |-> target == '0 && threshold == '0)
    else $error("event fields set without a release");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_DROP |-> pending_count == PEND_W'(QUEUE_DEPTH))
    else $error("insert dropped while table not full");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_count <= PEND_W'(QUEUE_DEPTH))
    else $error("pending count above table depth");

endmodule

bind timed_event_queue teq_checker u_teq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .kind          (out_ch.kind),
  .target        (out_ch.out_target),
  .threshold     (out_ch.out_threshold),
  .timer_now     (out_ch.timer_now),
  .pending_count (out_ch.pending_count)
);
